### rtl/gfa_pkg.sv
// ----------------------------------------------------------------------------
// gfa_pkg
// Shared widths, types and arithmetic helpers for the gravity force
// accumulator.
// ----------------------------------------------------------------------------
package gfa_pkg;

    // Fixed-point formats.
    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC_BITS     = 24;

    // Field and datapath widths.
    localparam int POS_W   = 32;
    localparam int MASS_W  = 32;
    localparam int CFG_W   = 32;
    localparam int APB_AW  = 3;
    localparam int AX_W    = 33;   // magnitude of a coordinate difference
    localparam int R2_W    = 66;   // dx^2 + dy^2
    localparam int ROOT_W  = 33;   // floor(sqrt(r2))
    localparam int SREM_W  = 35;   // square root remainder
    localparam int D_W     = 67;   // r2 plus the scaled softening term
    localparam int DEN_W   = 100;  // root * d
    localparam int MUL_AW  = 96;   // wide multiplier operand, three limbs
    localparam int MUL_BW  = 33;   // narrow multiplier operand
    localparam int MUL_PW  = 65;   // one limb product
    localparam int MUL_RW  = 129;  // full product
    // Holds the largest numerator (129 bits shifted by up to 16) and the
    // denominator shifted by the quotient limit (100 + 47 bits).
    localparam int DIV_W   = 148;
    localparam int Q_W     = 48;
    localparam int QBITS   = Q_W - 1;
    localparam int F_W     = 48;
    localparam int CNT_W   = 6;
    localparam int QDEPTH  = 2;

    localparam logic [Q_W-1:0]        MAG_LIM = Q_W'(1) << (Q_W - 1);
    localparam logic signed [F_W-1:0] F_MAX   = {1'b0, {(F_W-1){1'b1}}};
    localparam logic signed [F_W-1:0] F_MIN   = {1'b1, {(F_W-1){1'b0}}};

    // Register indexes on the configuration port.
    localparam logic REG_GRAV = 1'b0;
    localparam logic REG_SOFT = 1'b1;

    // One classified pair as it travels from the front end to the engine.
    typedef struct packed {
        logic [AX_W-1:0]   ax;
        logic [AX_W-1:0]   ay;
        logic              neg_x;
        logic              neg_y;
        logic [MASS_W-1:0] src_mass;
        logic [MASS_W-1:0] tgt_mass;
        logic              skip;
        logic              last;
    } pair_t;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [MUL_RW-1:0] result;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] q;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_DEN,
        ST_KGS,
        ST_KTM,
        ST_NX,
        ST_DIVX,
        ST_NY,
        ST_DIVY,
        ST_ACX,
        ST_ACY,
        ST_OUT
    } eng_state_t;

    // Saturating add of two Q24.24 values.
    function automatic logic signed [F_W-1:0] sat_add(input logic signed [F_W-1:0] a,
                                                      input logic signed [F_W-1:0] b);
        logic signed [F_W:0] s;
        s = {a[F_W-1], a} + {b[F_W-1], b};
        if (s[F_W] != s[F_W-1])
            return s[F_W] ? F_MIN : F_MAX;
        return s[F_W-1:0];
    endfunction

    // Applies a sign to a clipped magnitude; the positive side saturates.
    function automatic logic signed [F_W-1:0] signed_sat(input logic neg,
                                                         input logic [Q_W-1:0] q);
        if (neg)
            return F_W'(~q + 1'b1);
        return q[Q_W-1] ? F_MAX : F_W'(q);
    endfunction

    // Magnitude of a signed Q24.24 value.
    function automatic logic [Q_W-1:0] mag_of(input logic signed [F_W-1:0] f);
        return f[F_W-1] ? Q_W'(~f + 1'b1) : Q_W'(f);
    endfunction

endpackage

### rtl/gfa_if.sv
// ----------------------------------------------------------------------------
// gfa_if
// Valid/ready channels for body pairs in and force results out.
// ----------------------------------------------------------------------------
interface gfa_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] src_pos_x;
    logic signed [31:0] src_pos_y;
    logic        [31:0] src_mass;
    logic signed [31:0] tgt_pos_x;
    logic signed [31:0] tgt_pos_y;
    logic        [31:0] tgt_mass;
    logic               is_self;
    logic               last;

    modport source (output valid, src_pos_x, src_pos_y, src_mass, tgt_pos_x,
                    tgt_pos_y, tgt_mass, is_self, last, input ready);
    modport sink   (input valid, src_pos_x, src_pos_y, src_mass, tgt_pos_x,
                    tgt_pos_y, tgt_mass, is_self, last, output ready);
endinterface

interface gfa_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] accel_x;
    logic signed [47:0] accel_y;
    logic               mass_zero;

    modport source (output valid, force_x, force_y, accel_x, accel_y, mass_zero,
                    input ready);
    modport sink   (input valid, force_x, force_y, accel_x, accel_y, mass_zero,
                    output ready);
endinterface

### rtl/gfa_front.sv
// ----------------------------------------------------------------------------
// gfa_front
// Takes body pairs, forms the coordinate differences and marks pairs that
// add nothing, then hands them to the queue.
// ----------------------------------------------------------------------------
module gfa_front (
    input  logic          clk,
    input  logic          rst_n,
    gfa_in_if.sink        body_in,
    input  logic          q_full,
    output logic          q_push,
    output gfa_pkg::pair_t q_data
);
    import gfa_pkg::*;

    logic            v_reg;
    pair_t           ent_reg;
    pair_t           ent_next;
    logic [AX_W-1:0] dx;
    logic [AX_W-1:0] dy;
    logic            accept;

    // Differences are formed one bit wider so they never wrap.
    always_comb
    begin
        dx = {body_in.src_pos_x[POS_W-1], body_in.src_pos_x}
           - {body_in.tgt_pos_x[POS_W-1], body_in.tgt_pos_x};
        dy = {body_in.src_pos_y[POS_W-1], body_in.src_pos_y}
           - {body_in.tgt_pos_y[POS_W-1], body_in.tgt_pos_y};
        ent_next.neg_x    = dx[AX_W-1];
        ent_next.neg_y    = dy[AX_W-1];
        ent_next.ax       = dx[AX_W-1] ? (~dx + 1'b1) : dx;
        ent_next.ay       = dy[AX_W-1] ? (~dy + 1'b1) : dy;
        ent_next.src_mass = body_in.src_mass;
        ent_next.tgt_mass = body_in.tgt_mass;
        ent_next.skip     = body_in.is_self || (dx == '0 && dy == '0);
        ent_next.last     = body_in.last;
    end

    assign q_push        = v_reg && !q_full;
    assign body_in.ready = !v_reg || !q_full;
    assign accept        = body_in.valid && body_in.ready;
    assign q_data        = ent_reg;

    // Holding stage in front of the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (accept)
            v_reg <= 1'b1;
        else if (q_push)
            v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ent_reg <= ent_next;
    end

endmodule

### rtl/gfa_queue.sv
// ----------------------------------------------------------------------------
// gfa_queue
// Short queue of classified pairs between the front end and the engine.
// ----------------------------------------------------------------------------
module gfa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gfa_pkg::pair_t push_data,
    output logic           full,
    input  logic           pop,
    output gfa_pkg::pair_t pop_data,
    output logic           not_empty
);
    import gfa_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    pair_t            mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full      = (count_reg == (PTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/gfa_mul.sv
// ----------------------------------------------------------------------------
// gfa_mul
// Limb-serial multiplier: a 96-bit operand times a 33-bit operand, one
// 32-bit limb per cycle, most significant limb first.
// ----------------------------------------------------------------------------
module gfa_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  gfa_pkg::mul_req_t req,
    output gfa_pkg::mul_rsp_t rsp
);
    import gfa_pkg::*;

    logic [MUL_AW-1:0] a_reg;
    logic [MUL_BW-1:0] b_reg;
    logic [MUL_PW-1:0] prod_reg;
    logic [MUL_RW-1:0] acc_reg;
    logic [1:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [31:0]       limb;

    // Pick the limb for this step.
    always_comb
    begin
        case (step_reg)
            2'd0:    limb = a_reg[95:64];
            2'd1:    limb = a_reg[63:32];
            default: limb = a_reg[31:0];
        endcase
    end

    // Sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && step_reg == 2'd3;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Product register, then shift-and-add into the accumulator.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= MUL_PW'(limb) * MUL_PW'(b_reg);
            if (step_reg != 2'd0)
                acc_reg <= (acc_reg << 32) + MUL_RW'(prod_reg);
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

### rtl/gfa_div.sv
// ----------------------------------------------------------------------------
// gfa_div
// Restoring divider with the quotient clipped at 2^47: one quotient bit a
// cycle against a denominator that shifts right.
// ----------------------------------------------------------------------------
module gfa_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gfa_pkg::div_req_t req,
    output gfa_pkg::div_rsp_t rsp
);
    import gfa_pkg::*;

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dsh_reg;
    logic [QBITS-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             clip_reg;
    logic             done_reg;
    logic             ge;

    assign ge = (rem_reg >= dsh_reg);

    // Sequencing: the first step only checks for the clip.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QBITS);
            end
            else if (busy_reg)
            begin
                if ((cnt_reg == CNT_W'(QBITS) && ge) || cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            dsh_reg  <= DIV_W'(req.den) << QBITS;
            q_reg    <= '0;
            clip_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(QBITS))
                clip_reg <= ge;
            else
            begin
                if (ge)
                    rem_reg <= rem_reg - dsh_reg;
                q_reg <= {q_reg[QBITS-2:0], ge};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = clip_reg ? MAG_LIM : {1'b0, q_reg};

endmodule

### rtl/gfa_back.sv
// ----------------------------------------------------------------------------
// gfa_back
// Force engine: squares, square root, products and divisions for one pair,
// the running sums, and the acceleration and result register on the last
// pair.
// ----------------------------------------------------------------------------
module gfa_back #(
    parameter int POS_FRAC_BITS = gfa_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  gfa_pkg::pair_t           q_data,
    output logic                     q_pop,
    input  logic [gfa_pkg::CFG_W-1:0] grav,
    input  logic [gfa_pkg::CFG_W-1:0] softening,
    gfa_out_if.source                force_out
);
    import gfa_pkg::*;

    eng_state_t state_reg, state_next;
    pair_t      item_reg, item_next;
    logic                    wait_reg, wait_next;
    logic [R2_W-1:0]         r2_reg, r2_next;
    logic [R2_W-1:0]         rad_reg, rad_next;
    logic [SREM_W-1:0]       srem_reg, srem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [CNT_W-1:0]        scnt_reg, scnt_next;
    logic [D_W-1:0]          d_reg, d_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [MUL_AW-1:0]       k_reg, k_next;
    logic [DIV_W-1:0]        num_reg, num_next;
    logic signed [F_W-1:0]   sum_x_reg, sum_x_next;
    logic signed [F_W-1:0]   sum_y_reg, sum_y_next;
    logic signed [F_W-1:0]   acc_x_reg, acc_x_next;
    logic signed [F_W-1:0]   acc_y_reg, acc_y_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [F_W-1:0]   o_fx_reg, o_fy_reg, o_ax_reg, o_ay_reg;
    logic                    o_mz_reg;
    logic                    load_out;
    logic [SREM_W+1:0]       remsh;
    logic [SREM_W+1:0]       trial;
    mul_req_t                mul_req;
    mul_rsp_t                mul_rsp;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    gfa_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
    gfa_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    // One step of the digit-by-digit square root.
    assign remsh = {srem_reg, rad_reg[R2_W-1:R2_W-2]};
    assign trial = {2'b00, root_reg, 2'b01};

    // Next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        wait_next      = wait_reg;
        r2_next        = r2_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        scnt_next      = scnt_reg;
        d_next         = d_reg;
        den_next       = den_reg;
        k_next         = k_reg;
        num_next       = num_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        out_valid_next = out_valid_reg && !force_out.ready;
        load_out       = 1'b0;
        q_pop          = 1'b0;
        mul_req        = '0;
        div_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_data;
                    if (!q_data.skip)
                        state_next = ST_SQX;
                    else if (q_data.last)
                        state_next = ST_ACX;
                end
            end

            ST_SQX, ST_SQY:
            begin
                mul_req.a = MUL_AW'(state_reg == ST_SQX ? item_reg.ax : item_reg.ay);
                mul_req.b = state_reg == ST_SQX ? item_reg.ax : item_reg.ay;
                if (!wait_reg)
                begin
                    mul_req.start = 1'b1;
                    wait_next     = 1'b1;
                end
                else if (mul_rsp.done)
                begin
                    wait_next = 1'b0;
                    if (state_reg == ST_SQX)
                    begin
                        r2_next    = R2_W'(mul_rsp.result);
                        state_next = ST_SQY;
                    end
                    else
                    begin
                        r2_next    = r2_reg + R2_W'(mul_rsp.result);
                        rad_next   = r2_reg + R2_W'(mul_rsp.result);
                        srem_next  = '0;
                        root_next  = '0;
                        scnt_next  = CNT_W'(ROOT_W - 1);
                        state_next = ST_ROOT;
                    end
                end
            end

            ST_ROOT:
            begin
                d_next   = D_W'(r2_reg) + (D_W'(softening) << POS_FRAC_BITS);
                rad_next = rad_reg << 2;
                if (remsh >= trial)
                begin
                    srem_next = SREM_W'(remsh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = SREM_W'(remsh);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (scnt_reg == '0)
                    state_next = ST_DEN;
                else
                    scnt_next = scnt_reg - 1'b1;
            end

            ST_DEN, ST_KGS, ST_KTM, ST_NX, ST_NY:
            begin
                case (state_reg)
                    ST_DEN:
                    begin
                        mul_req.a = MUL_AW'(d_reg);
                        mul_req.b = root_reg;
                    end
                    ST_KGS:
                    begin
                        mul_req.a = MUL_AW'(grav);
                        mul_req.b = MUL_BW'(item_reg.src_mass);
                    end
                    ST_KTM:
                    begin
                        mul_req.a = k_reg;
                        mul_req.b = MUL_BW'(item_reg.tgt_mass);
                    end
                    ST_NX:
                    begin
                        mul_req.a = k_reg;
                        mul_req.b = item_reg.ax;
                    end
                    default:
                    begin
                        mul_req.a = k_reg;
                        mul_req.b = item_reg.ay;
                    end
                endcase
                if (!wait_reg)
                begin
                    mul_req.start = 1'b1;
                    wait_next     = 1'b1;
                end
                else if (mul_rsp.done)
                begin
                    wait_next = 1'b0;
                    case (state_reg)
                        ST_DEN:
                        begin
                            den_next   = DEN_W'(mul_rsp.result);
                            state_next = ST_KGS;
                        end
                        ST_KGS:
                        begin
                            k_next     = MUL_AW'(mul_rsp.result);
                            state_next = ST_KTM;
                        end
                        ST_KTM:
                        begin
                            k_next     = MUL_AW'(mul_rsp.result);
                            state_next = ST_NX;
                        end
                        ST_NX:
                        begin
                            num_next   = DIV_W'(mul_rsp.result) << (OUT_FRAC_BITS - POS_FRAC_BITS);
                            state_next = ST_DIVX;
                        end
                        default:
                        begin
                            num_next   = DIV_W'(mul_rsp.result) << (OUT_FRAC_BITS - POS_FRAC_BITS);
                            state_next = ST_DIVY;
                        end
                    endcase
                end
            end

            ST_DIVX, ST_DIVY:
            begin
                div_req.num = num_reg;
                div_req.den = den_reg;
                if (!wait_reg)
                begin
                    div_req.start = 1'b1;
                    wait_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    wait_next = 1'b0;
                    if (state_reg == ST_DIVX)
                    begin
                        sum_x_next = sat_add(sum_x_reg, signed_sat(item_reg.neg_x, div_rsp.q));
                        state_next = ST_NY;
                    end
                    else
                    begin
                        sum_y_next = sat_add(sum_y_reg, signed_sat(item_reg.neg_y, div_rsp.q));
                        state_next = item_reg.last ? ST_ACX : ST_IDLE;
                    end
                end
            end

            ST_ACX, ST_ACY:
            begin
                div_req.num = DIV_W'(mag_of(state_reg == ST_ACX ? sum_x_reg : sum_y_reg))
                              << POS_FRAC_BITS;
                div_req.den = DEN_W'(item_reg.tgt_mass);
                if (item_reg.tgt_mass == '0)
                begin
                    acc_x_next = '0;
                    acc_y_next = '0;
                    state_next = ST_OUT;
                end
                else if (!wait_reg)
                begin
                    div_req.start = 1'b1;
                    wait_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    wait_next = 1'b0;
                    if (state_reg == ST_ACX)
                    begin
                        acc_x_next = signed_sat(sum_x_reg[F_W-1], div_rsp.q);
                        state_next = ST_ACY;
                    end
                    else
                    begin
                        acc_y_next = signed_sat(sum_y_reg[F_W-1], div_rsp.q);
                        state_next = ST_OUT;
                    end
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || force_out.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        r2_reg    <= r2_next;
        rad_reg   <= rad_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
        scnt_reg  <= scnt_next;
        d_reg     <= d_next;
        den_reg   <= den_next;
        k_reg     <= k_next;
        num_reg   <= num_next;
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        if (load_out)
        begin
            o_fx_reg <= sum_x_reg;
            o_fy_reg <= sum_y_reg;
            o_ax_reg <= acc_x_reg;
            o_ay_reg <= acc_y_reg;
            o_mz_reg <= (item_reg.tgt_mass == '0);
        end
    end

    assign force_out.valid     = out_valid_reg;
    assign force_out.force_x   = o_fx_reg;
    assign force_out.force_y   = o_fy_reg;
    assign force_out.accel_x   = o_ax_reg;
    assign force_out.accel_y   = o_ay_reg;
    assign force_out.mass_zero = o_mz_reg;

    // The multiplier only answers a request that the engine is waiting on.
    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> wait_reg)
        else $error("multiplier finished without an outstanding request");

    // The divider never returns more than the clip value.
    a_div_clip: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (div_rsp.q <= MAG_LIM))
        else $error("quotient above the clip value");

    // Emitting a result clears the sums and presents the beat.
    a_out_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && load_out) |=>
            (sum_x_reg == '0 && sum_y_reg == '0 && out_valid_reg))
        else $error("sums not cleared or result not presented");

endmodule

### rtl/gravity_force_accumulator.sv
// ----------------------------------------------------------------------------
// gravity_force_accumulator
// Softened 2-D gravitational force on one target body, summed over a stream
// of source bodies, with the acceleration given on the last pair.
//
//   Channel    Dir  Beat carries
//   body_in    in   source and target position and mass, is_self, last
//   force_out  out  force_x/y, accel_x/y (Q24.24), mass_zero
//   APB        in   grav_const at 0x0, softening at 0x4
//
// A contributing pair runs seven limb-serial products, a 33-step square root
// and two 48-step divisions in one shared engine. A self or coincident pair
// is only popped from the queue; a last pair adds two more divisions unless
// the target mass is zero. The front stage and a two-entry queue keep
// taking beats while the engine works; a result waits in its own register,
// so the engine only halts when a second result is ready before the first
// beat is taken. Reset clears the sums and all control state at once.
// ----------------------------------------------------------------------------
module gravity_force_accumulator #(
    parameter int POS_FRAC_BITS = gfa_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    gfa_in_if.sink                     body_in,
    gfa_out_if.source                  force_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gfa_pkg::APB_AW-1:0] paddr,
    input  logic [gfa_pkg::CFG_W-1:0]  pwdata,
    output logic [gfa_pkg::CFG_W-1:0]  prdata,
    output logic                       pready
);
    import gfa_pkg::*;

    logic [CFG_W-1:0] grav_reg;
    logic [CFG_W-1:0] soft_reg;
    logic             wr_en;
    logic             q_full;
    logic             q_push;
    pair_t            push_data;
    logic             q_pop;
    pair_t            pop_data;
    logic             q_valid;

    // Configuration registers.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_SOFT) ? soft_reg : grav_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg <= CFG_W'(65536);
            soft_reg <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_GRAV)
                grav_reg <= pwdata;
            else
                soft_reg <= pwdata;
        end
    end

    // Front end, queue and engine.
    gfa_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .body_in (body_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (push_data)
    );

    gfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .not_empty (q_valid)
    );

    gfa_back #(
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .grav      (grav_reg),
        .softening (soft_reg),
        .force_out (force_out)
    );

endmodule

### sim/gravity_force_accumulator_checker.sv
// ----------------------------------------------------------------------------
// gravity_force_accumulator_checker
// Watches the body and force channels and the register port, predicts the
// summed force and acceleration of every target, and compares each result
// beat with the oldest prediction field by field.
// ----------------------------------------------------------------------------
module gravity_force_accumulator_checker #(
    parameter int POS_FRAC_BITS = gfa_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    gfa_in_if                          body_in,
    gfa_out_if                         force_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [gfa_pkg::APB_AW-1:0] paddr,
    input  logic [gfa_pkg::CFG_W-1:0]  pwdata,
    output int                         pending,
    output int                         mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [191:0] CLIP = 192'(1) << 47;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] accel_x;
        logic signed [47:0] accel_y;
        logic               mass_zero;
    } force_result_t;

    logic [31:0]        grav;
    logic [31:0]        softening;
    logic signed [47:0] sum_x;
    logic signed [47:0] sum_y;
    force_result_t      results_due[$];

    // Quotient clipped at the magnitude limit.
    function automatic logic [47:0] div_clipped(input logic [191:0] num,
                                                input logic [191:0] den);
        logic [191:0] q;
        q = num / den;
        return (q > CLIP) ? 48'(CLIP) : q[47:0];
    endfunction

    function automatic logic signed [47:0] apply_sign(input logic neg, input logic [47:0] mag);
        if (neg)
            return 48'(-mag);
        return mag[47] ? gfa_pkg::F_MAX : mag;
    endfunction

    function automatic logic signed [47:0] add_clamped(input logic signed [47:0] a,
                                                      input logic signed [47:0] b);
        logic signed [48:0] s;
        s = 49'(a) + 49'(b);
        if (s > 49'(gfa_pkg::F_MAX))
            return gfa_pkg::F_MAX;
        if (s < 49'(gfa_pkg::F_MIN))
            return gfa_pkg::F_MIN;
        return s[47:0];
    endfunction

    function automatic logic [191:0] floor_root(input logic [191:0] v);
        logic [191:0] c;
        logic [191:0] t;
        c = '0;
        for (int b = 32; b >= 0; b--)
        begin
            t = c | (192'(1) << b);
            if (t * t <= v)
                c = t;
        end
        return c;
    endfunction

    function automatic logic signed [47:0] accel_from(input logic signed [47:0] f,
                                                     input logic [31:0] mass);
        logic [47:0] mag;
        mag = f[47] ? 48'(-f) : 48'(f);
        return apply_sign(f[47], div_clipped(192'(mag) << POS_FRAC_BITS, 192'(mass)));
    endfunction

    // Force of one source on the target, one component per call.
    function automatic logic signed [47:0] pair_force(input logic signed [32:0] dx,
                                                     input logic [191:0] den,
                                                     input logic [191:0] k);
        logic [191:0] a;
        a = dx[32] ? 192'(-dx) : 192'(dx);
        return apply_sign(dx[32],
                          div_clipped((k * a) << (gfa_pkg::OUT_FRAC_BITS - POS_FRAC_BITS), den));
    endfunction

    assign pending = results_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [191:0]       r2;
        logic [191:0]       den;
        logic [191:0]       k;
        force_result_t      exp_r;
        force_result_t      got;
        if (!rst_n)
        begin
            grav <= 32'd65536;
            softening <= '0;
            sum_x <= '0;
            sum_y <= '0;
            mismatches <= 0;
            results_due.delete();
        end
        else
        begin
            // Register writes.
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == gfa_pkg::REG_GRAV)
                    grav <= pwdata;
                else
                    grav <= grav;
                if (paddr[2] == gfa_pkg::REG_SOFT)
                    softening <= pwdata;
            end

            // Accepted body beat: accumulate and predict on the last source.
            if (body_in.valid && body_in.ready)
            begin
                dx = 33'(body_in.src_pos_x) - 33'(body_in.tgt_pos_x);
                dy = 33'(body_in.src_pos_y) - 33'(body_in.tgt_pos_y);
                exp_r.force_x = sum_x;
                exp_r.force_y = sum_y;
                if (!body_in.is_self && (dx != 0 || dy != 0))
                begin
                    // Squares are formed at full width before widening.
                    r2 = 192'(66'(dx) * 66'(dx)) + 192'(66'(dy) * 66'(dy));
                    den = floor_root(r2) * (r2 + (192'(softening) << POS_FRAC_BITS));
                    k = 192'(grav) * 192'(body_in.src_mass) * 192'(body_in.tgt_mass);
                    exp_r.force_x = add_clamped(sum_x, pair_force(dx, den, k));
                    exp_r.force_y = add_clamped(sum_y, pair_force(dy, den, k));
                end
                if (body_in.last)
                begin
                    exp_r.mass_zero = (body_in.tgt_mass == 0);
                    exp_r.accel_x = '0;
                    exp_r.accel_y = '0;
                    if (!exp_r.mass_zero)
                    begin
                        exp_r.accel_x = accel_from(exp_r.force_x, body_in.tgt_mass);
                        exp_r.accel_y = accel_from(exp_r.force_y, body_in.tgt_mass);
                    end
                    results_due.push_back(exp_r);
                    sum_x <= '0;
                    sum_y <= '0;
                end
                else
                begin
                    sum_x <= exp_r.force_x;
                    sum_y <= exp_r.force_y;
                end
            end

            // Accepted result beat against the oldest prediction.
            if (force_out.valid && force_out.ready)
            begin
                got = '{force_out.force_x, force_out.force_y, force_out.accel_x,
                        force_out.accel_y, force_out.mass_zero};
                if (results_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result beat with none expected: %p", $realtime, got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_r = results_due.pop_front();
                    if (got !== exp_r)
                    begin
                        if (mismatches < 10)
                            $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                                     $realtime, exp_r, got);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

### sim/gravity_force_accumulator_tb.sv
// ----------------------------------------------------------------------------
// gravity_force_accumulator_tb
// Drives directed and random source streams through the force accumulator
// under several register settings, with bursty input and a stalling output,
// and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module gravity_force_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 400;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [gfa_pkg::APB_AW-1:0] paddr = '0;
    logic [gfa_pkg::CFG_W-1:0]  pwdata = '0;
    logic [gfa_pkg::CFG_W-1:0]  prdata;
    logic                       pready;
    int                         pending;
    int                         mismatches;
    int                         burst_left = 0;
    int                         cycles = 0;
    int                         stall_mode = 0;

    gfa_in_if  body_in();
    gfa_out_if force_out();

    gravity_force_accumulator DUT (
        .clk(clk), .rst_n(rst_n), .body_in(body_in), .force_out(force_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gravity_force_accumulator_checker checker_i (
        .clk(clk), .rst_n(rst_n), .body_in(body_in), .force_out(force_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .pending(pending), .mismatches(mismatches)
    );

    always #5 clk = ~clk;

    // Receiver stall pattern: always ready, random, or a slow periodic pattern.
    always @(posedge clk)
    begin
        if (cycles % 500 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: force_out.ready <= 1'b1;
            1: force_out.ready <= ($urandom_range(0, 9) < 6);
            default: force_out.ready <= ((cycles % 37) > 20);
        endcase
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gravity_force_accumulator verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h7fff_ffff;
            1: v = 32'h8000_0000;
            2, 3: v = $urandom;
            default:
            begin
                v = $urandom_range(0, 1 << 22);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'hffff_ffff;
            2, 3: return $urandom;
            default: return $urandom_range(1, 1 << 20);
        endcase
    endfunction

    // One body beat; the sender pauses between bursts of random length.
    task automatic send_pair(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sm, input logic [31:0] tx,
                             input logic [31:0] ty, input logic [31:0] tm,
                             input logic slf, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                body_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        body_in.valid <= 1'b1;
        body_in.src_pos_x <= sx;
        body_in.src_pos_y <= sy;
        body_in.src_mass <= sm;
        body_in.tgt_pos_x <= tx;
        body_in.tgt_pos_y <= ty;
        body_in.tgt_mass <= tm;
        body_in.is_self <= slf;
        body_in.last <= lst;
        do @(posedge clk); while (!body_in.ready);
    endtask

    // Lets every result drain and the engine settle before a register write.
    task automatic drain();
        body_in.valid <= 1'b0;
        burst_left = 0;
        // The checker records the final beat's prediction at this edge.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic reg_write(input logic reg_idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Groups of sources acting on one target, the last beat closing the group.
    task automatic random_targets(input int count);
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tm;
        logic [31:0] sx;
        logic [31:0] sy;
        int          len;
        int          sent;
        sent = 0;
        while (sent < count)
        begin
            tx = pick_coord();
            ty = pick_coord();
            tm = pick_mass();
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                sx = pick_coord();
                sy = pick_coord();
                if ($urandom_range(0, 15) == 0)
                begin
                    sx = tx;
                    sy = ty;
                end
                if ($urandom_range(0, 7) == 0)
                    tm = pick_mass();
                send_pair(sx, sy, pick_mass(), tx, ty, tm,
                          ($urandom_range(0, 11) == 0), (i == len - 1));
            end
            sent += len;
        end
    endtask

    initial
    begin
        body_in.valid = 1'b0;
        body_in.src_pos_x = '0;
        body_in.src_pos_y = '0;
        body_in.src_mass = '0;
        body_in.tgt_pos_x = '0;
        body_in.tgt_pos_y = '0;
        body_in.tgt_mass = '0;
        body_in.is_self = 1'b0;
        body_in.last = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, self and coincident pairs, zero target mass.
        send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 1'b0, 1'b1);
        send_pair(32'h8000_0000, 32'h0, 32'h0001_0000, 32'h7fff_ffff, 32'h0,
                  32'h0001_0000, 1'b0, 1'b1);
        send_pair(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0,
                  32'h0001_0000, 1'b0, 1'b0);
        send_pair(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0,
                  32'h0001_0000, 1'b1, 1'b0);
        send_pair(32'h1234_5678, 32'h0, 32'h0001_0000, 32'h1234_5678, 32'h0,
                  32'h0001_0000, 1'b0, 1'b1);
        send_pair(32'h0000_0001, 32'hffff_ffff, 32'h0100_0000, 32'h0, 32'h0,
                  32'h0, 1'b0, 1'b1);
        send_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        send_pair(32'hffff_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0, 32'h0,
                  32'h0000_0001, 1'b0, 1'b1);
        send_pair(32'h0, 32'h0, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 1'b1, 1'b1);
        random_targets(220);
        drain();

        // Largest constant, no softening.
        reg_write(gfa_pkg::REG_GRAV, 32'hffff_ffff);
        reg_write(gfa_pkg::REG_SOFT, 32'h0);
        random_targets(250);
        drain();

        // No gravity, largest softening.
        reg_write(gfa_pkg::REG_GRAV, 32'h0);
        reg_write(gfa_pkg::REG_SOFT, 32'hffff_ffff);
        random_targets(100);
        drain();

        // Random settings.
        for (int p = 0; p < 4; p++)
        begin
            reg_write(gfa_pkg::REG_GRAV, ($urandom_range(0, 1) ? $urandom
                                                                : $urandom_range(0, 1 << 20)));
            reg_write(gfa_pkg::REG_SOFT, ($urandom_range(0, 1) ? $urandom
                                                                : $urandom_range(0, 1 << 12)));
            random_targets(110);
            drain();
        end

        if (mismatches == 0)
            $display("gravity_force_accumulator verification clean");
        else
            $display("gravity_force_accumulator verification failed");
        $finish;
    end

endmodule
